### src/orthonormal_basis_3d_assert.svh
// ----------------------------------------------------------------------------
// orthonormal basis assertion macros
// concurrent check helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ORTHONORMAL_BASIS_3D_ASSERT_SVH
`define ORTHONORMAL_BASIS_3D_ASSERT_SVH
`ifndef SYNTH
// checked outside reset
`define OBD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define OBD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define OBD_ASSERT(lbl, prop, msg)
`define OBD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### src/obd_pkg.sv
// ----------------------------------------------------------------------------
// obd_pkg
// shared constants of the orthonormal basis block
// ----------------------------------------------------------------------------
package obd_pkg;
    // width of the unit-vector result fields
    localparam int UNIT_WIDTH = 18;
    // number of vector components
    localparam int NCOMP = 3;
endpackage

### src/obd_norm.sv
// ----------------------------------------------------------------------------
// obd_norm
// pipelined 3-vector normalizer: squares, bit-per-stage square root,
// bit-per-stage restoring divide, sideband carried alongside
// ----------------------------------------------------------------------------
module obd_norm #(
    parameter int IW = 34,
    parameter int F  = 16,
    parameter int SW = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [obd_pkg::NCOMP*IW-1:0]      i_vec,
    input  logic [SW-1:0]                     i_side,
    output logic                              o_valid,
    output logic [obd_pkg::NCOMP*(F+2)-1:0]   o_vec,
    output logic [SW-1:0]                     o_side
);
    localparam int NC   = obd_pkg::NCOMP;
    localparam int MW   = IW;
    localparam int SUMW = 2 * MW + 2;
    localparam int RW   = MW + 1;
    localparam int DW   = MW + F + 2;
    localparam int QW   = F + 1;
    localparam int UB   = F + 2;

    // square stage
    logic [2*MW-1:0] r_sq [NC];
    logic [MW-1:0]   r_mag_sq [NC];
    logic [NC-1:0]   r_sgn_sq;
    logic [SW-1:0]   r_side_sq;
    logic            r_v_sq;

    logic [MW-1:0] n_mag [NC];
    logic [NC-1:0] n_sgn;

    always_comb begin
        for (int i = 0; i < NC; i++) begin
            n_sgn[i] = i_vec[i*IW + IW - 1];
            n_mag[i] = n_sgn[i] ? MW'(-$signed(i_vec[i*IW +: IW]))
                                : MW'(i_vec[i*IW +: IW]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_sq <= 1'b0;
        end else if (i_en) begin
            r_v_sq <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NC; i++) begin
                r_sq[i]     <= (2*MW)'(n_mag[i]) * (2*MW)'(n_mag[i]);
                r_mag_sq[i] <= n_mag[i];
            end
            r_sgn_sq  <= n_sgn;
            r_side_sq <= i_side;
        end
    end

    // square root stages, index 0 holds the sum of squares
    logic [SUMW-1:0] r_rem  [0:RW];
    logic [RW-1:0]   r_root [0:RW];
    logic [MW-1:0]   r_smag [0:RW][NC];
    logic [NC-1:0]   r_ssgn [0:RW];
    logic [SW-1:0]   r_sside[0:RW];
    logic            r_sv   [0:RW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (i_en) begin
            r_sv[0] <= r_v_sq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]   <= SUMW'(r_sq[0]) + SUMW'(r_sq[1]) + SUMW'(r_sq[2]);
            r_root[0]  <= '0;
            r_smag[0]  <= r_mag_sq;
            r_ssgn[0]  <= r_sgn_sq;
            r_sside[0] <= r_side_sq;
        end
    end

    for (genvar s = 0; s < RW; s++) begin : g_sqrt
        localparam int B = RW - 1 - s;
        logic [SUMW:0] d;
        logic          take;

        // trial (r + 2^b)^2 - r^2 against the remaining radicand
        always_comb begin
            d    = ((SUMW+1)'(r_root[s]) << (B + 1)) | ((SUMW+1)'(1) << (2 * B));
            take = (SUMW+1)'(r_rem[s]) >= d;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[s+1] <= 1'b0;
            end else if (i_en) begin
                r_sv[s+1] <= r_sv[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1]   <= take ? SUMW'((SUMW+1)'(r_rem[s]) - d) : r_rem[s];
                r_root[s+1]  <= r_root[s] | (RW'(take) << B);
                r_smag[s+1]  <= r_smag[s];
                r_ssgn[s+1]  <= r_ssgn[s];
                r_sside[s+1] <= r_sside[s];
            end
        end
    end

    // divide stages, one quotient bit per stage for all three components
    logic [DW-1:0] r_drem [0:QW][NC];
    logic [QW-1:0] r_dq   [0:QW][NC];
    logic [RW-1:0] r_droot[0:QW];
    logic [NC-1:0] r_dsgn [0:QW];
    logic [SW-1:0] r_dside[0:QW];
    logic          r_dv   [0:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (i_en) begin
            r_dv[0] <= r_sv[RW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NC; i++) begin
                r_drem[0][i] <= DW'(r_smag[RW][i]) << F;
                r_dq[0][i]   <= '0;
            end
            r_droot[0] <= r_root[RW];
            r_dsgn[0]  <= r_ssgn[RW];
            r_dside[0] <= r_sside[RW];
        end
    end

    for (genvar t = 0; t < QW; t++) begin : g_div
        localparam int K = QW - 1 - t;
        logic [DW-1:0] d;
        logic [NC-1:0] take;

        always_comb begin
            d = DW'(r_droot[t]) << K;
            for (int i = 0; i < NC; i++) begin
                take[i] = (r_drem[t][i] >= d) && (r_droot[t] != '0);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[t+1] <= 1'b0;
            end else if (i_en) begin
                r_dv[t+1] <= r_dv[t];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < NC; i++) begin
                    r_drem[t+1][i] <= take[i] ? (r_drem[t][i] - d) : r_drem[t][i];
                    r_dq[t+1][i]   <= r_dq[t][i] | (QW'(take[i]) << K);
                end
                r_droot[t+1] <= r_droot[t];
                r_dsgn[t+1]  <= r_dsgn[t];
                r_dside[t+1] <= r_dside[t];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NC; i++) begin
            o_vec[i*UB +: UB] = r_dsgn[QW][i] ? UB'(-$signed({1'b0, r_dq[QW][i]}))
                                              : UB'({1'b0, r_dq[QW][i]});
        end
    end

    assign o_valid = r_dv[QW];
    assign o_side  = r_dside[QW];
endmodule

### src/obd_cross.sv
// ----------------------------------------------------------------------------
// obd_cross
// two-stage fixed-point cross product p x q, scaled down with truncation
// toward zero
// ----------------------------------------------------------------------------
module obd_cross #(
    parameter int F  = 16,
    parameter int PW = 18,
    parameter int QW = 32,
    parameter int OW = 34,
    parameter int SW = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [obd_pkg::NCOMP*PW-1:0]  i_p,
    input  logic [obd_pkg::NCOMP*QW-1:0]  i_q,
    input  logic [SW-1:0]                 i_side,
    output logic                          o_valid,
    output logic [obd_pkg::NCOMP*OW-1:0]  o_r,
    output logic [SW-1:0]                 o_side
);
    localparam int NC = obd_pkg::NCOMP;
    localparam int MW = PW + QW;
    localparam int DW = MW + 1;

    logic signed [PW-1:0] p [NC];
    logic signed [QW-1:0] q [NC];

    always_comb begin
        for (int i = 0; i < NC; i++) begin
            p[i] = $signed(i_p[i*PW +: PW]);
            q[i] = $signed(i_q[i*QW +: QW]);
        end
    end

    // products: plus term and minus term of each component
    logic signed [MW-1:0] r_mp [NC];
    logic signed [MW-1:0] r_mm [NC];
    logic [SW-1:0]        r_side1;
    logic                 r_v1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v1    <= i_valid;
            o_valid <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mp[0] <= MW'(p[1]) * MW'(q[2]);
            r_mm[0] <= MW'(p[2]) * MW'(q[1]);
            r_mp[1] <= MW'(p[2]) * MW'(q[0]);
            r_mm[1] <= MW'(p[0]) * MW'(q[2]);
            r_mp[2] <= MW'(p[0]) * MW'(q[1]);
            r_mm[2] <= MW'(p[1]) * MW'(q[0]);
            r_side1 <= i_side;
        end
    end

    logic signed [DW-1:0] diff [NC];
    logic [DW-1:0]        dmag [NC];
    logic [DW-1:0]        dsh  [NC];
    logic [OW-1:0]        n_r  [NC];

    always_comb begin
        for (int i = 0; i < NC; i++) begin
            diff[i] = DW'(r_mp[i]) - DW'(r_mm[i]);
            dmag[i] = diff[i][DW-1] ? DW'(-diff[i]) : DW'(diff[i]);
            dsh[i]  = dmag[i] >> F;
            n_r[i]  = diff[i][DW-1] ? OW'(-dsh[i]) : OW'(dsh[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NC; i++) begin
                o_r[i*OW +: OW] <= n_r[i];
            end
            o_side <= r_side1;
        end
    end
endmodule

### src/orthonormal_basis_3d.sv
// ----------------------------------------------------------------------------
// orthonormal_basis_3d
// orthonormal basis (u, v, w) from two fixed-point 3-vectors a and b
// ----------------------------------------------------------------------------
// One request carries a and b, one result carries u = a/|a|, w = c/|c| with
// c = u x b, v = w x u, and a degenerate flag. When every component of c
// truncates to zero the result holds u, the original b in v, a zero w and a
// set degenerate flag. Square roots are floor roots of the exact sum of
// squares; divides truncate toward zero; a zero vector normalizes to zero.
// The block is one stall-gated pipeline: it takes a request every cycle
// while not stalled and delivers the matching result in order. Its depth
// is set by the two normalizers, each with one square-root bit and one
// quotient bit per stage, plus two cross-product units of two stages and
// the output register. A stall on the result side while a result is held
// freezes the whole pipeline, and the request side sees it as its own
// stall in the same cycle.
// ----------------------------------------------------------------------------
`include "orthonormal_basis_3d_assert.svh"

module orthonormal_basis_3d #(
    parameter int FRAC_BITS  = 16,
    parameter int COMP_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request side
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [COMP_WIDTH-1:0]        i_a_x,
    input  logic signed [COMP_WIDTH-1:0]        i_a_y,
    input  logic signed [COMP_WIDTH-1:0]        i_a_z,
    input  logic signed [COMP_WIDTH-1:0]        i_b_x,
    input  logic signed [COMP_WIDTH-1:0]        i_b_y,
    input  logic signed [COMP_WIDTH-1:0]        i_b_z,
    // result side
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [obd_pkg::UNIT_WIDTH-1:0] o_u_x,
    output logic signed [obd_pkg::UNIT_WIDTH-1:0] o_u_y,
    output logic signed [obd_pkg::UNIT_WIDTH-1:0] o_u_z,
    output logic signed [COMP_WIDTH-1:0]        o_v_x,
    output logic signed [COMP_WIDTH-1:0]        o_v_y,
    output logic signed [COMP_WIDTH-1:0]        o_v_z,
    output logic signed [obd_pkg::UNIT_WIDTH-1:0] o_w_x,
    output logic signed [obd_pkg::UNIT_WIDTH-1:0] o_w_y,
    output logic signed [obd_pkg::UNIT_WIDTH-1:0] o_w_z,
    output logic                                o_degenerate
);
    localparam int NC = obd_pkg::NCOMP;
    localparam int UW = obd_pkg::UNIT_WIDTH;
    localparam int CW = COMP_WIDTH;
    localparam int F  = FRAC_BITS;
    // unit vector component: magnitude up to 2^F
    localparam int UB = F + 2;
    // cross product u x b: magnitude up to 2^CW
    localparam int CB = CW + 2;
    // cross product w x u: magnitude up to 2^(F+1)
    localparam int VB = F + 3;
    // sideband widths along the pipe
    localparam int S1 = NC * CW;
    localparam int S2 = NC * UB + NC * CW;
    localparam int S3 = S2 + 1;
    localparam int S4 = S3 + NC * UB;

    // whole pipe advances unless a finished result is held
    logic en;
    logic r_out_valid;
    assign en         = !r_out_valid || !i_out_stall;
    assign o_in_stall = !en;

    // stage group 1: normalize a, carry b
    logic          v1;
    logic [NC*UB-1:0] u1;
    logic [S1-1:0] side1;

    obd_norm #(.IW(CW), .F(F), .SW(S1)) u_norm_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_vec   ({i_a_z, i_a_y, i_a_x}),
        .i_side  ({i_b_z, i_b_y, i_b_x}),
        .o_valid (v1),
        .o_vec   (u1),
        .o_side  (side1)
    );

    // stage group 2: c = u x b
    logic             v2;
    logic [NC*CB-1:0] c2;
    logic [S2-1:0]    side2;
    logic             degen2;

    obd_cross #(.F(F), .PW(UB), .QW(CW), .OW(CB), .SW(S2)) u_cross_ub (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v1),
        .i_p     (u1),
        .i_q     (side1),
        .i_side  ({u1, side1}),
        .o_valid (v2),
        .o_r     (c2),
        .o_side  (side2)
    );

    // degenerate when every truncated component of c is zero
    assign degen2 = (c2 == '0);

    // stage group 3: normalize c
    logic             v3;
    logic [NC*UB-1:0] w3;
    logic [S3-1:0]    side3;

    obd_norm #(.IW(CB), .F(F), .SW(S3)) u_norm_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v2),
        .i_vec   (c2),
        .i_side  ({side2, degen2}),
        .o_valid (v3),
        .o_vec   (w3),
        .o_side  (side3)
    );

    // stage group 4: v = w x u
    logic             v4;
    logic [NC*VB-1:0] vv4;
    logic [S4-1:0]    side4;

    obd_cross #(.F(F), .PW(UB), .QW(UB), .OW(VB), .SW(S4)) u_cross_wu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v3),
        .i_p     (w3),
        .i_q     (side3[S3-1 -: NC*UB]),
        .i_side  ({side3, w3}),
        .o_valid (v4),
        .o_r     (vv4),
        .o_side  (side4)
    );

    // sideband layout: {u, b, degenerate, w}
    logic [NC*UB-1:0] u4;
    logic [NC*CW-1:0] b4;
    logic             degen4;
    logic [NC*UB-1:0] w4;

    assign w4     = side4[NC*UB-1:0];
    assign degen4 = side4[NC*UB];
    assign b4     = side4[NC*UB + 1 +: NC*CW];
    assign u4     = side4[S4-1 -: NC*UB];

    // output register: degenerate results pass b through and zero w
    logic [UW-1:0] n_u [NC];
    logic [CW-1:0] n_v [NC];
    logic [UW-1:0] n_w [NC];

    always_comb begin
        for (int i = 0; i < NC; i++) begin
            n_u[i] = UW'($signed(u4[i*UB +: UB]));
            if (degen4) begin
                n_v[i] = b4[i*CW +: CW];
                n_w[i] = '0;
            end else begin
                n_v[i] = CW'($signed(vv4[i*VB +: VB]));
                n_w[i] = UW'($signed(w4[i*UB +: UB]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_u_x        <= n_u[0];
            o_u_y        <= n_u[1];
            o_u_z        <= n_u[2];
            o_v_x        <= n_v[0];
            o_v_y        <= n_v[1];
            o_v_z        <= n_v[2];
            o_w_x        <= n_w[0];
            o_w_y        <= n_w[1];
            o_w_z        <= n_w[2];
            o_degenerate <= degen4;
        end
    end

    assign o_out_valid = r_out_valid;

    // a held result is never dropped
    `OBD_ASSERT(a_hold_result, (o_out_valid && i_out_stall) |=> o_out_valid, "result lost under stall")
    // degenerate results carry a zero w
    `OBD_ASSERT(a_degen_zero_w, (o_out_valid && o_degenerate) |-> (o_w_x == '0 && o_w_y == '0 && o_w_z == '0), "degenerate result with nonzero w")
    // nothing comes out right after reset
    `OBD_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid, "result valid after reset")
endmodule
